>>> sv/assert_macros.svh
// assertion macros used by the list engine datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (prop)) else $error(msg);

// condition in one cycle implies a condition in the next one
`define PLE_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

>>> sv/ple_pkg.sv
// shared types and codes of the positional list engine
`default_nettype none

package ple_pkg;

    // request opcodes
    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_TRAVERSE  = 3'd6
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_INS2,
        S_DEL2,
        S_EMIT,
        S_TRAV
    } t_state;

    // what the decoded request needs
    typedef enum logic [2:0] {
        K_DONE,
        K_INS_FIRST,
        K_DEL_LAST,
        K_INS,
        K_DEL,
        K_TRAV
    } t_kind;

    // source of the store read address
    typedef enum logic [1:0] {
        RSEL_HEAD,
        RSEL_CUR,
        RSEL_NEXT
    } t_rsel;

    // commands from controller to datapath
    typedef struct packed {
        logic  load_req;
        logic  decode;
        t_rsel rsel;
        logic  step;
        logic  ins_first;
        logic  ins_link_new;
        logic  ins_link_prev;
        logic  del_last;
        logic  mark_victim;
        logic  del_finish;
        logic  emit_result;
        logic  emit_elem;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  hops_zero;
        logic  out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/positional_list_engine_unit.sv
// positional list engine top level: controller and datapath
// sequence: error, empty-list insert and last-element delete go from decode straight to emit;
//   other inserts and deletes walk n links (up to count-1), then a link-finish state, then emit
// traverse: after decode, one element per cycle while the output can take it
// throughput: one request at a time, taken the cycle after its last result is loaded
// reset: synchronous, active low; clears head, fill count, free map, result valid and control state only
`default_nettype none

module positional_list_engine_unit import ple_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [2:0]  i_cmd,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic        [5:0]  i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_element_value,
    output logic                    o_last_of_run,
    output logic             [5:0]  o_element_count
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequencer
    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // stores and registers
    ple_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_value (o_element_value),
        .o_last_of_run   (o_last_of_run),
        .o_element_count (o_element_count)
    );

endmodule

`default_nettype wire

>>> sv/ple_ctrl.sv
// controller state machine of the positional list engine
`default_nettype none

module ple_ctrl import ple_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_ctl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.rsel = RSEL_CUR;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.decode = 1'b1;
                o_ctl.rsel   = RSEL_HEAD;
                unique case (i_stat.kind)
                    K_INS_FIRST: begin
                        o_ctl.ins_first = 1'b1;
                        n_state         = S_EMIT;
                    end
                    K_DEL_LAST: begin
                        o_ctl.del_last = 1'b1;
                        n_state        = S_EMIT;
                    end
                    K_INS, K_DEL: n_state = S_WALK;
                    K_TRAV:       n_state = S_TRAV;
                    default:      n_state = S_EMIT;
                endcase
            end
            S_WALK: begin
                // one link per cycle until the predecessor is reached
                if (!i_stat.hops_zero) begin
                    o_ctl.step = 1'b1;
                    o_ctl.rsel = RSEL_NEXT;
                end else if (i_stat.kind == K_INS) begin
                    o_ctl.ins_link_new = 1'b1;
                    n_state            = S_INS2;
                end else begin
                    o_ctl.mark_victim = 1'b1;
                    o_ctl.rsel        = RSEL_NEXT;
                    n_state           = S_DEL2;
                end
            end
            S_INS2: begin
                o_ctl.ins_link_prev = 1'b1;
                n_state             = S_EMIT;
            end
            S_DEL2: begin
                o_ctl.del_finish = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TRAV: begin
                // one element per cycle while the output can take it
                if (i_stat.out_free) begin
                    o_ctl.emit_elem = 1'b1;
                    if (i_stat.hops_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.step = 1'b1;
                        o_ctl.rsel = RSEL_NEXT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/ple_datapath.sv
// datapath of the positional list engine: slot stores, list registers, result register
`default_nettype none
`include "assert_macros.svh"

module ple_datapath import ple_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_ctl,
    output t_dp_stat                o_stat,
    input  wire logic        [2:0]  i_cmd,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic        [5:0]  i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_element_value,
    output logic                    o_last_of_run,
    output logic             [5:0]  o_element_count
);

    localparam int SW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = CW + 7;

    // slot stores
    logic [VALUE_WIDTH-1:0] elem_mem [CAPACITY];
    logic [SW-1:0]          link_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] elem_q;
    logic [SW-1:0]          link_q;

    // list registers
    logic [SW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [CAPACITY-1:0] r_free;

    // latched request and walk registers
    logic [2:0]             r_cmd;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [5:0]             r_pos;
    logic [SW-1:0]          r_idx;
    logic [CW-1:0]          r_hops;
    logic [SW-1:0]          r_slot;
    logic                   r_front;
    t_status                r_status;

    // result register
    logic         r_out_valid;
    t_status      r_out_status;
    logic [31:0]  r_out_value;
    logic         r_out_last;
    logic [5:0]   r_out_count;

    logic [SW-1:0]          free_slot;
    logic [SW-1:0]          raddr;
    logic                   link_we;
    logic [SW-1:0]          link_waddr;
    logic [SW-1:0]          link_wdata;
    logic                   elem_we;
    logic [SW-1:0]          elem_waddr;
    logic [63:0]            value_ext;
    logic [VALUE_WIDTH+31:0] elem_ext;
    logic [CW+5:0]          count_ext;
    logic                   out_free;
    logic                   hops_zero;

    t_kind                  d_kind;
    t_status                d_status;
    logic                   d_front;
    logic [CMPW-1:0]        d_hops;
    logic [CMPW-1:0]        cnt_w;
    logic [CMPW-1:0]        pos_w;

    // value fitting on the way in and out
    assign value_ext = {{32{i_item_value[31]}}, i_item_value};
    assign elem_ext  = {{32{elem_q[VALUE_WIDTH-1]}}, elem_q};
    assign count_ext = {6'd0, r_count};

    assign out_free  = !r_out_valid || i_out_ready;
    assign hops_zero = (r_hops == '0);

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    // request decode against the current fill
    always_comb begin
        cnt_w    = CMPW'(r_count);
        pos_w    = CMPW'(r_pos);
        d_kind   = K_DONE;
        d_status = ST_OK;
        d_front  = 1'b0;
        d_hops   = cnt_w - CMPW'(1);
        unique case (r_cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                if (cnt_w >= CMPW'(CAPACITY)) begin
                    d_status = ST_FULL;
                end else if (cnt_w == '0) begin
                    d_kind = K_INS_FIRST;
                end else if (r_cmd == CMD_INS_POS &&
                             (pos_w == '0 || pos_w > cnt_w + CMPW'(1))) begin
                    d_status = ST_NOT_FOUND;
                end else begin
                    d_kind  = K_INS;
                    d_front = (r_cmd == CMD_INS_FRONT) ||
                              (r_cmd == CMD_INS_POS && pos_w == CMPW'(1));
                    if (r_cmd == CMD_INS_POS && pos_w != CMPW'(1)) begin
                        d_hops = pos_w - CMPW'(2);
                    end
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (cnt_w == '0) begin
                    d_status = ST_EMPTY;
                end else if (r_cmd == CMD_DEL_POS &&
                             (pos_w == '0 || pos_w > cnt_w)) begin
                    d_status = ST_NOT_FOUND;
                end else if (cnt_w == CMPW'(1)) begin
                    d_kind = K_DEL_LAST;
                end else begin
                    d_kind  = K_DEL;
                    d_front = (r_cmd == CMD_DEL_FRONT) ||
                              (r_cmd == CMD_DEL_POS && pos_w == CMPW'(1));
                    if (r_cmd == CMD_DEL_BACK) begin
                        d_hops = cnt_w - CMPW'(2);
                    end else if (r_cmd == CMD_DEL_POS && pos_w != CMPW'(1)) begin
                        d_hops = pos_w - CMPW'(2);
                    end
                end
            end
            CMD_TRAVERSE: begin
                if (cnt_w == '0) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_kind = K_TRAV;
                end
            end
            default: d_status = ST_OK;
        endcase
    end

    assign o_stat.kind      = d_kind;
    assign o_stat.hops_zero = hops_zero;
    assign o_stat.out_free  = out_free;

    // read address select
    always_comb begin
        unique case (i_ctl.rsel)
            RSEL_HEAD: raddr = r_head;
            RSEL_NEXT: raddr = link_q;
            default:   raddr = r_idx;
        endcase
    end

    // link store write port
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_idx;
        link_wdata = link_q;
        priority if (i_ctl.ins_first) begin
            link_we    = 1'b1;
            link_waddr = free_slot;
            link_wdata = free_slot;
        end else if (i_ctl.ins_link_new) begin
            link_we    = 1'b1;
            link_waddr = r_slot;
            link_wdata = link_q;
        end else if (i_ctl.ins_link_prev) begin
            link_we    = 1'b1;
            link_waddr = r_idx;
            link_wdata = r_slot;
        end else if (i_ctl.del_finish) begin
            link_we    = 1'b1;
            link_waddr = r_idx;
            link_wdata = link_q;
        end
    end

    assign elem_we    = i_ctl.ins_first || i_ctl.ins_link_prev;
    assign elem_waddr = i_ctl.ins_first ? free_slot : r_slot;

    // stores with registered read
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= r_value;
        end
        elem_q <= elem_mem[raddr];
    end

    // head, fill count, free map and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_free      <= {CAPACITY{1'b1}};
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.ins_first) begin
                r_head            <= free_slot;
                r_free[free_slot] <= 1'b0;
                r_count           <= r_count + CW'(1);
            end
            if (i_ctl.ins_link_prev) begin
                if (r_front) begin
                    r_head <= r_slot;
                end
                r_free[r_slot] <= 1'b0;
                r_count        <= r_count + CW'(1);
            end
            if (i_ctl.del_last) begin
                r_head         <= '0;
                r_free[r_head] <= 1'b1;
                r_count        <= r_count - CW'(1);
            end
            if (i_ctl.del_finish) begin
                if (r_front) begin
                    r_head <= link_q;
                end
                r_free[r_slot] <= 1'b1;
                r_count        <= r_count - CW'(1);
            end
            if (i_ctl.emit_result || i_ctl.emit_elem) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, walk and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_req) begin
            r_cmd   <= i_cmd;
            r_value <= value_ext[VALUE_WIDTH-1:0];
            r_pos   <= i_position;
        end
        if (i_ctl.decode) begin
            r_status <= d_status;
            r_front  <= d_front;
            r_hops   <= d_hops[CW-1:0];
            r_idx    <= r_head;
            r_slot   <= free_slot;
        end
        if (i_ctl.step) begin
            r_idx  <= link_q;
            r_hops <= r_hops - CW'(1);
        end
        if (i_ctl.mark_victim) begin
            r_slot <= link_q;
        end
        if (i_ctl.emit_result) begin
            r_out_status <= r_status;
            r_out_value  <= '0;
            r_out_last   <= 1'b1;
            r_out_count  <= count_ext[5:0];
        end else if (i_ctl.emit_elem) begin
            r_out_status <= ST_OK;
            r_out_value  <= elem_ext[31:0];
            r_out_last   <= hops_zero;
            r_out_count  <= count_ext[5:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_element_value = r_out_value;
    assign o_last_of_run   = r_out_last;
    assign o_element_count = r_out_count;

    // consistency checks
    `PLE_ASSERT(a_count_range, r_count <= CW'(CAPACITY), "fill count above capacity")
    `PLE_ASSERT(a_free_balance, ($countones(r_free) + int'(r_count)) == CAPACITY, "free map off")
    `PLE_ASSERT(a_emit_room, (i_ctl.emit_result || i_ctl.emit_elem) |-> out_free, "result lost")
    `PLE_ASSERT_NEXT(a_emit_valid, i_ctl.emit_result || i_ctl.emit_elem, r_out_valid, "not valid")

endmodule

`default_nettype wire
